FILE: hw/rtl/dtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants for dead-time compensation
// Register map, fixed field widths, sign and scaling constants, and the
// pipeline latencies that the top level and the checker rely on.
// ----------------------------------------------------------------------------
package dtc_pkg;

  // Default sample width
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_BUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CUR_TH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NEGATE    = 3'd4;

  // Register widths and reset values
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned TH_W   = 15;
  localparam logic [GAIN_W-1:0] GAIN_MAX_RST = 16'hFFFF;

  // Smoothed sign, Q15 magnitude: full scale is 1.0 = 32768
  localparam int unsigned SIGN_W = 16;
  localparam logic [SIGN_W-1:0] SIGN_ONE = 16'h8000;

  // 1/sqrt(3) in Q0.16
  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;

  // One quotient bit per divider stage
  localparam int unsigned DIV_STEPS = TH_W;

  // Lane: entry stage, divider stages, product stage, rounding stage
  localparam int unsigned LANE_LAT = DIV_STEPS + 3;
  // Merge: difference stage and four stages of divide-by-three
  localparam int unsigned MRG_LAT  = 5;
  // Edges from the accepting edge to the edge that samples the strobe
  localparam int unsigned OUT_LAT  = LANE_LAT + MRG_LAT + 2;

  // Configuration register file
  typedef struct packed {
    logic [15:0]     min_bus;
    logic [GAIN_W-1:0] gain_base;
    logic [GAIN_W-1:0] gain_max;
    logic [TH_W-1:0] cur_th;
    logic            negate;
  } cfg_t;

endpackage : dtc_pkg
`default_nettype wire

FILE: hw/rtl/dtc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_lane: per-phase correction lane
// Forms the smoothed current sign through a pipelined restoring divider
// (one quotient bit per stage), scales it by the bus correction magnitude
// and rounds it to the signed phase correction.
// ----------------------------------------------------------------------------
module dtc_lane #(
  parameter int unsigned VALUE_WIDTH = dtc_pkg::VALUE_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire dtc_pkg::cfg_t             cfg_i,
  input  wire logic signed [VALUE_WIDTH-1:0] cur_i,
  input  wire logic [VALUE_WIDTH-1:0]    m_i,
  output logic signed [VALUE_WIDTH:0]    d_o
);
  import dtc_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned XW = (VW > TH_W) ? VW : TH_W;
  localparam int unsigned PW = VW + SIGN_W;
  localparam logic [PW:0] ROUND_Q15 = (PW+1)'(16384);

  typedef struct packed {
    logic neg;
    logic full;
    logic use_q;
  } sgn_flags_t;

  logic [VW-1:0]      mag;
  logic [XW-1:0]      mag_x;
  logic [XW-1:0]      th_x;
  logic               hard;
  logic               over;
  sgn_flags_t         flg_nxt;

  logic [TH_W-1:0]      rem_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_r [DIV_STEPS+1];
  sgn_flags_t           flg_r [DIV_STEPS+1];

  logic [SIGN_W-1:0]  smag;
  logic [PW-1:0]      prod_r;
  logic               neg_r;
  logic [PW:0]        rnd;
  logic [VW-1:0]      dmag;
  logic signed [VW:0] d_nxt;
  logic signed [VW:0] d_r;

  // Classify the current against the threshold band
  always_comb begin
    mag     = cur_i[VW-1] ? VW'(-cur_i) : VW'(cur_i);
    mag_x   = XW'(mag);
    th_x    = XW'(cfg_i.cur_th);
    hard    = (cfg_i.cur_th == '0);
    over    = (mag_x >= th_x);
    flg_nxt.neg   = cur_i[VW-1];
    flg_nxt.full  = hard ? (mag != '0) : over;
    flg_nxt.use_q = !hard && !over;
  end

  // Load the divider: inside the band the magnitude is below the threshold
  always_ff @(posedge clk) begin
    rem_r[0] <= mag_x[TH_W-1:0];
    quo_r[0] <= '0;
    flg_r[0] <= flg_nxt;
  end

  // Restoring divide of mag * 2^15 by the threshold, one bit per stage
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [TH_W:0] r2;
    logic          ge;

    assign r2 = {rem_r[j-1], 1'b0};
    assign ge = (r2 >= {1'b0, cfg_i.cur_th});

    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? TH_W'(r2 - {1'b0, cfg_i.cur_th}) : r2[TH_W-1:0];
      quo_r[j] <= {quo_r[j-1][DIV_STEPS-2:0], ge};
      flg_r[j] <= flg_r[j-1];
    end
  end

  // Pick the sign magnitude: full scale, quotient, or zero
  always_comb begin
    if (flg_r[DIV_STEPS].full) begin
      smag = SIGN_ONE;
    end else if (flg_r[DIV_STEPS].use_q) begin
      smag = SIGN_W'(quo_r[DIV_STEPS]);
    end else begin
      smag = '0;
    end
  end

  // Scale by the correction magnitude
  always_ff @(posedge clk) begin
    prod_r <= PW'(m_i) * PW'(smag);
    neg_r  <= flg_r[DIV_STEPS].neg;
  end

  // Round the Q15 product half away from zero and apply the sign
  always_comb begin
    rnd   = {1'b0, prod_r} + ROUND_Q15;
    dmag  = rnd[VW+14:15];
    d_nxt = (neg_r ^ cfg_i.negate) ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule : dtc_lane
`default_nettype wire

FILE: hw/rtl/dtc_div3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_div3: pipelined rounded divide by three
// Returns round(x / 3), halves away from zero, in four stages. The
// magnitude is split in two halves and each half goes through a small
// reciprocal multiply, like one long-division step in a wide radix.
// The input magnitude must stay below 2^(IN_W-1) - 1.
// ----------------------------------------------------------------------------
module dtc_div3 #(
  parameter int unsigned IN_W = dtc_pkg::VALUE_WIDTH_DEF + 3
) (
  input  wire                     clk,
  input  wire logic signed [IN_W-1:0] x_i,
  output logic signed [IN_W-1:0]  q_o
);
  import dtc_pkg::*;

  localparam int unsigned MW   = IN_W - 1;
  localparam int unsigned HALF = MW / 2;
  localparam int unsigned HW   = MW - HALF;
  localparam int unsigned S1   = HW + 2;
  localparam int unsigned N2   = HALF + 2;
  localparam int unsigned S2   = N2 + 2;
  localparam logic [S1-1:0] RECIP1 = S1'((2**S1) / 3 + 1);
  localparam logic [S2-1:0] RECIP2 = S2'((2**S2) / 3 + 1);

  logic [IN_W-1:0]    abs_x;
  logic [MW-1:0]      mag_r;
  logic               neg1_r;

  logic [HW+S1-1:0]   p1;
  logic [HW-1:0]      qhi2_r;
  logic [HW-1:0]      hi2_r;
  logic [HALF-1:0]    lo2_r;
  logic               neg2_r;

  logic [HW-1:0]      rhi;
  logic [N2-1:0]      n2;
  logic [N2+S2-1:0]   p2;
  logic [HW-1:0]      qhi3_r;
  logic [HALF-1:0]    qlo3_r;
  logic               neg3_r;

  logic [MW-1:0]      qmag;
  logic signed [IN_W-1:0] q_r;

  // Magnitude plus one turns floor into round-to-nearest
  assign abs_x = x_i[IN_W-1] ? IN_W'(-x_i) : IN_W'(x_i);

  always_ff @(posedge clk) begin
    mag_r  <= abs_x[MW-1:0] + MW'(1);
    neg1_r <= x_i[IN_W-1];
  end

  // Divide the upper half
  assign p1 = (HW+S1)'(mag_r[MW-1:HALF]) * (HW+S1)'(RECIP1);

  always_ff @(posedge clk) begin
    qhi2_r <= p1[HW+S1-1:S1];
    hi2_r  <= mag_r[MW-1:HALF];
    lo2_r  <= mag_r[HALF-1:0];
    neg2_r <= neg1_r;
  end

  // Carry the upper remainder down and divide the lower half
  always_comb begin
    rhi = hi2_r - HW'(qhi2_r * HW'(3));
    n2  = {rhi[1:0], lo2_r};
    p2  = (N2+S2)'(n2) * (N2+S2)'(RECIP2);
  end

  always_ff @(posedge clk) begin
    qhi3_r <= qhi2_r;
    qlo3_r <= p2[S2+HALF-1:S2];
    neg3_r <= neg2_r;
  end

  // Join the halves and restore the sign
  assign qmag = {qhi3_r, qlo3_r};

  always_ff @(posedge clk) begin
    q_r <= neg3_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  assign q_o = q_r;

endmodule : dtc_div3
`default_nettype wire

FILE: hw/rtl/dtc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_merge: combine the three lane corrections
// Removes the common mode of the phase corrections and forms the beta
// axis term (d_v - d_w) / sqrt(3), both rounded half away from zero.
// ----------------------------------------------------------------------------
module dtc_merge #(
  parameter int unsigned VALUE_WIDTH = dtc_pkg::VALUE_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire logic signed [VALUE_WIDTH:0]   d_u_i,
  input  wire logic signed [VALUE_WIDTH:0]   d_v_i,
  input  wire logic signed [VALUE_WIDTH:0]   d_w_i,
  output logic signed [VALUE_WIDTH+2:0] c_u_o,
  output logic signed [VALUE_WIDTH+2:0] c_v_o,
  output logic signed [VALUE_WIDTH+2:0] c_w_o,
  output logic signed [VALUE_WIDTH+2:0] beta_o
);
  import dtc_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned NW = VW + 3;
  localparam int unsigned BW = VW + 2;
  localparam int unsigned BPW = BW + 16;
  localparam logic [BPW:0] ROUND_Q16 = (BPW+1)'(32768);

  logic signed [NW-1:0] n_u_r;
  logic signed [NW-1:0] n_v_r;
  logic signed [NW-1:0] n_w_r;
  logic signed [BW-1:0] bdiff_r;

  logic [BW-1:0]        bmag_r;
  logic                 bneg1_r;
  logic [BPW-1:0]       bprod_r;
  logic                 bneg2_r;
  logic [BPW:0]         brnd;
  logic [BW-1:0]        bq;
  logic signed [NW-1:0] bt3_r;
  logic signed [NW-1:0] bt4_r;

  // Form 2*d_j minus the other two, and the beta difference
  always_ff @(posedge clk) begin
    n_u_r   <= (NW'(d_u_i) <<< 1) - NW'(d_v_i) - NW'(d_w_i);
    n_v_r   <= (NW'(d_v_i) <<< 1) - NW'(d_u_i) - NW'(d_w_i);
    n_w_r   <= (NW'(d_w_i) <<< 1) - NW'(d_u_i) - NW'(d_v_i);
    bdiff_r <= BW'(d_v_i) - BW'(d_w_i);
  end

  // Common mode removal, one divider per phase
  dtc_div3 #(.IN_W(NW)) u_div3_u (.clk(clk), .x_i(n_u_r), .q_o(c_u_o));
  dtc_div3 #(.IN_W(NW)) u_div3_v (.clk(clk), .x_i(n_v_r), .q_o(c_v_o));
  dtc_div3 #(.IN_W(NW)) u_div3_w (.clk(clk), .x_i(n_w_r), .q_o(c_w_o));

  // Beta term: magnitude, scale, round, then hold one stage to line up
  always_ff @(posedge clk) begin
    bmag_r  <= bdiff_r[BW-1] ? BW'(-bdiff_r) : BW'(bdiff_r);
    bneg1_r <= bdiff_r[BW-1];
    bprod_r <= BPW'(bmag_r) * BPW'(INV_SQRT3_Q16);
    bneg2_r <= bneg1_r;
  end

  always_comb begin
    brnd = {1'b0, bprod_r} + ROUND_Q16;
    bq   = brnd[BPW-1:16];
  end

  always_ff @(posedge clk) begin
    bt3_r <= bneg2_r ? -$signed({1'b0, bq}) : $signed({1'b0, bq});
    bt4_r <= bt3_r;
  end

  assign beta_o = bt4_r;

endmodule : dtc_merge
`default_nettype wire

FILE: hw/rtl/deadtime_compensation_alpha_beta.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadtime_compensation_alpha_beta: inverter dead-time compensation
// Adds a per-phase dead-time correction to an alpha/beta voltage command,
// with a smoothed current sign, common mode removal and saturation.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+---------------------------
//   input   | start, busy, in_*                  | word taken: start & !busy
//   result  | out_strobe, out_*                  | one cycle, no back-pressure
//   config  | cfg_valid, cfg_ready, cfg_index,   | write: cfg_valid & cfg_ready
//           | cfg_wdata                          |
//
// A new word is taken every cycle while busy is low. Each result passes the
// input register, the lanes, the merge and the output register; the 15-stage
// sign divider in each lane is the longest part of that path.
// Reset is synchronous and active low; it clears the pipeline valids and
// loads the register reset values. busy is high for one cycle after reset.
// Results are never held: the strobe marks each one for a single cycle.
// ----------------------------------------------------------------------------
module deadtime_compensation_alpha_beta #(
  parameter int unsigned VALUE_WIDTH = dtc_pkg::VALUE_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input words
  input  wire                                 start,
  output logic                                busy,
  input  wire logic [VALUE_WIDTH-1:0]         in_bus_voltage,
  input  wire logic signed [VALUE_WIDTH-1:0]  in_current_u,
  input  wire logic signed [VALUE_WIDTH-1:0]  in_current_v,
  input  wire logic signed [VALUE_WIDTH-1:0]  in_current_w,
  input  wire logic signed [VALUE_WIDTH-1:0]  in_volt_alpha_in,
  input  wire logic signed [VALUE_WIDTH-1:0]  in_volt_beta_in,
  // result words
  output logic                                out_strobe,
  output logic signed [VALUE_WIDTH-1:0]       out_volt_alpha_out,
  output logic signed [VALUE_WIDTH-1:0]       out_volt_beta_out,
  output logic signed [VALUE_WIDTH-1:0]       out_correction_u,
  output logic signed [VALUE_WIDTH-1:0]       out_correction_v,
  output logic signed [VALUE_WIDTH-1:0]       out_correction_w,
  output logic                                out_applied,
  // configuration writes
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dtc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dtc_pkg::*;

  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned TOT   = LANE_LAT + MRG_LAT;
  localparam int unsigned KVW   = VW + GAIN_W;
  localparam int unsigned CMP_W = (VW > 16) ? VW : 16;
  localparam int unsigned SW    = VW + 4;
  localparam int unsigned NPH   = 3;
  localparam logic [KVW:0] ROUND_Q16 = (KVW+1)'(32768);

  // Clamp a wide signed value into the output range
  function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] x);
    logic [SW-VW:0] top;
    logic signed [VW-1:0] res;
    top = x[SW-1:VW-1];
    if ((&top) || !(|top)) begin
      res = x[VW-1:0];
    end else if (x[SW-1]) begin
      res = {1'b1, {(VW-1){1'b0}}};
    end else begin
      res = {1'b0, {(VW-1){1'b1}}};
    end
    return res;
  endfunction

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic busy_r;

  logic                 s0_vld_r;
  logic [VW-1:0]        vbus_s0_r;
  logic signed [VW-1:0] cur_s0_r [NPH];
  logic signed [VW-1:0] va_s0_r;
  logic signed [VW-1:0] vb_s0_r;

  logic [GAIN_W-1:0]    k;
  logic [KVW-1:0]       kv_r;
  logic [KVW:0]         kv_rnd;
  logic [VW-1:0]        m_pipe_r [DIV_STEPS];

  logic                 vld_pipe_r [TOT];
  logic                 byp_pipe_r [TOT];
  logic signed [VW-1:0] va_pipe_r  [TOT];
  logic signed [VW-1:0] vb_pipe_r  [TOT];

  logic signed [VW:0]   d_lane [NPH];
  logic signed [VW+2:0] c_u;
  logic signed [VW+2:0] c_v;
  logic signed [VW+2:0] c_w;
  logic signed [VW+2:0] beta_t;

  logic                 strobe_r;
  logic signed [VW-1:0] alpha_r;
  logic signed [VW-1:0] beta_r;
  logic signed [VW-1:0] corr_u_r;
  logic signed [VW-1:0] corr_v_r;
  logic signed [VW-1:0] corr_w_r;
  logic                 applied_r;

  // Decode configuration writes; indexes past the map are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_MIN_BUS:   cfg_nxt.min_bus   = cfg_wdata;
        CFG_IDX_GAIN_BASE: cfg_nxt.gain_base = cfg_wdata;
        CFG_IDX_GAIN_MAX:  cfg_nxt.gain_max  = cfg_wdata;
        CFG_IDX_CUR_TH:    cfg_nxt.cur_th    = cfg_wdata[TH_W-1:0];
        CFG_IDX_NEGATE:    cfg_nxt.negate    = cfg_wdata[0];
        default:           cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_bus   <= '0;
      cfg_r.gain_base <= '0;
      cfg_r.gain_max  <= GAIN_MAX_RST;
      cfg_r.cur_th    <= '0;
      cfg_r.negate    <= 1'b0;
      busy_r          <= 1'b1;
    end else begin
      cfg_r  <= cfg_nxt;
      busy_r <= 1'b0;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    vbus_s0_r   <= in_bus_voltage;
    cur_s0_r[0] <= in_current_u;
    cur_s0_r[1] <= in_current_v;
    cur_s0_r[2] <= in_current_w;
    va_s0_r     <= in_volt_alpha_in;
    vb_s0_r     <= in_volt_beta_in;
  end

  // Clamped gain times bus voltage, then round to the correction magnitude
  assign k      = (cfg_r.gain_base < cfg_r.gain_max) ? cfg_r.gain_base : cfg_r.gain_max;
  assign kv_rnd = {1'b0, kv_r} + ROUND_Q16;

  always_ff @(posedge clk) begin
    kv_r        <= KVW'(k) * KVW'(vbus_s0_r);
    m_pipe_r[0] <= kv_rnd[KVW-1:16];
    for (int i = 1; i < DIV_STEPS; i++) begin
      m_pipe_r[i] <= m_pipe_r[i-1];
    end
  end

  // Advance valids alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOT; i++) begin
        vld_pipe_r[i] <= 1'b0;
      end
    end else begin
      vld_pipe_r[0] <= s0_vld_r;
      for (int i = 1; i < TOT; i++) begin
        vld_pipe_r[i] <= vld_pipe_r[i-1];
      end
    end
  end

  // Hold the bypass decision and the command alongside the lanes
  always_ff @(posedge clk) begin
    byp_pipe_r[0] <= (CMP_W'(vbus_s0_r) < CMP_W'(cfg_r.min_bus)) || (k == '0);
    va_pipe_r[0]  <= va_s0_r;
    vb_pipe_r[0]  <= vb_s0_r;
    for (int i = 1; i < TOT; i++) begin
      byp_pipe_r[i] <= byp_pipe_r[i-1];
      va_pipe_r[i]  <= va_pipe_r[i-1];
      vb_pipe_r[i]  <= vb_pipe_r[i-1];
    end
  end

  // One lane per phase
  for (genvar p = 0; p < NPH; p++) begin : g_lane
    dtc_lane #(.VALUE_WIDTH(VW)) u_lane (
      .clk   (clk),
      .cfg_i (cfg_r),
      .cur_i (cur_s0_r[p]),
      .m_i   (m_pipe_r[DIV_STEPS-1]),
      .d_o   (d_lane[p])
    );
  end

  dtc_merge #(.VALUE_WIDTH(VW)) u_merge (
    .clk    (clk),
    .d_u_i  (d_lane[0]),
    .d_v_i  (d_lane[1]),
    .d_w_i  (d_lane[2]),
    .c_u_o  (c_u),
    .c_v_o  (c_v),
    .c_w_o  (c_w),
    .beta_o (beta_t)
  );

  // Apply, saturate or pass the command through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_pipe_r[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (byp_pipe_r[TOT-1]) begin
      alpha_r   <= va_pipe_r[TOT-1];
      beta_r    <= vb_pipe_r[TOT-1];
      corr_u_r  <= '0;
      corr_v_r  <= '0;
      corr_w_r  <= '0;
      applied_r <= 1'b0;
    end else begin
      alpha_r   <= sat_v(SW'(va_pipe_r[TOT-1]) + SW'(c_u));
      beta_r    <= sat_v(SW'(vb_pipe_r[TOT-1]) + SW'(beta_t));
      corr_u_r  <= sat_v(SW'(c_u));
      corr_v_r  <= sat_v(SW'(c_v));
      corr_w_r  <= sat_v(SW'(c_w));
      applied_r <= 1'b1;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_volt_alpha_out = alpha_r;
  assign out_volt_beta_out  = beta_r;
  assign out_correction_u   = corr_u_r;
  assign out_correction_v   = corr_v_r;
  assign out_correction_w   = corr_w_r;
  assign out_applied        = applied_r;

endmodule : deadtime_compensation_alpha_beta
`default_nettype wire

FILE: hw/rtl/dtc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_checker: port-level checks for dead-time compensation
// Watches busy after reset, result timing against accepted words, and the
// bypass path from the command inputs to the outputs.
// ----------------------------------------------------------------------------
module dtc_checker #(
  parameter int unsigned VALUE_WIDTH = dtc_pkg::VALUE_WIDTH_DEF
) (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             start,
  input wire                             busy,
  input wire logic signed [VALUE_WIDTH-1:0] in_volt_alpha_in,
  input wire logic signed [VALUE_WIDTH-1:0] in_volt_beta_in,
  input wire                             out_strobe,
  input wire logic signed [VALUE_WIDTH-1:0] out_volt_alpha_out,
  input wire logic signed [VALUE_WIDTH-1:0] out_volt_beta_out,
  input wire logic signed [VALUE_WIDTH-1:0] out_correction_u,
  input wire logic signed [VALUE_WIDTH-1:0] out_correction_v,
  input wire logic signed [VALUE_WIDTH-1:0] out_correction_w,
  input wire                             out_applied
);
  import dtc_pkg::*;

  // Reset raises busy for the following cycle
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // Every result word traces back to a word taken a fixed latency earlier
  a_strobe_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, OUT_LAT))
    else $error("result word without a matching input word");

  // Bypassed words carry zero corrections
  a_bypass_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_applied) |->
      (out_correction_u == '0 && out_correction_v == '0 && out_correction_w == '0))
    else $error("nonzero correction on a bypassed word");

  // Bypassed words pass the command unchanged
  a_bypass_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_applied) |->
      (out_volt_alpha_out == $past(in_volt_alpha_in, OUT_LAT) &&
       out_volt_beta_out == $past(in_volt_beta_in, OUT_LAT)))
    else $error("bypassed command changed");

endmodule : dtc_checker

bind deadtime_compensation_alpha_beta dtc_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_dtc_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_volt_alpha_in   (in_volt_alpha_in),
  .in_volt_beta_in    (in_volt_beta_in),
  .out_strobe         (out_strobe),
  .out_volt_alpha_out (out_volt_alpha_out),
  .out_volt_beta_out  (out_volt_beta_out),
  .out_correction_u   (out_correction_u),
  .out_correction_v   (out_correction_v),
  .out_correction_w   (out_correction_w),
  .out_applied        (out_applied)
);
`default_nettype wire

FILE: test/deadtime_compensation_alpha_beta_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadtime_compensation_alpha_beta_tb: self-checking bench for dead-time comp
// Drives control samples through the start/busy port and reprograms the
// registers between phases while the pipeline is empty. Each result word is
// compared field by field with an in-bench fixed-point predictor or a typed
// expectation. The run has a short directed table, then randomized register
// phases with random sender gaps; a watchdog ends the run if progress stops.
// ----------------------------------------------------------------------------
module deadtime_compensation_alpha_beta_tb;
  import dtc_pkg::*;

  localparam int unsigned W = VALUE_WIDTH_DEF;
  localparam int NUM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int STALL_LIMIT = 2000;
  localparam longint SIGN_FULL = longint'(SIGN_ONE);
  localparam longint RECIP_SQRT3 = longint'(INV_SQRT3_Q16);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Indexes with no register behind them
  localparam cfg_idx_t CFG_IDX_SPARE = CFG_IDX_NEGATE + 1'b1;
  localparam cfg_idx_t CFG_IDX_TOP   = '1;

  localparam logic ROW_WRITE = 1'b1;
  localparam logic ROW_PLAIN = 1'b0;
  localparam logic ROW_TYPED = 1'b1;
  localparam logic ROW_PRED  = 1'b0;

  typedef struct packed {
    logic [W-1:0] bus;
    logic [W-1:0] iu;
    logic [W-1:0] iv;
    logic [W-1:0] iw;
    logic [W-1:0] va;
    logic [W-1:0] vb;
  } sample_word_t;

  typedef struct packed {
    logic [W-1:0] va_out;
    logic [W-1:0] vb_out;
    logic [W-1:0] cor_u;
    logic [W-1:0] cor_v;
    logic [W-1:0] cor_w;
    logic         applied;
  } comp_word_t;

  typedef struct packed {
    logic         wr_en;
    cfg_idx_t     wr_idx;
    logic [15:0]  wr_data;
    sample_word_t smp;
    logic         typed;
    logic [W-1:0] want_a;
    logic [W-1:0] want_b;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [W-1:0] in_bus_voltage = '0;
  logic signed [W-1:0] in_current_u = '0;
  logic signed [W-1:0] in_current_v = '0;
  logic signed [W-1:0] in_current_w = '0;
  logic signed [W-1:0] in_volt_alpha_in = '0;
  logic signed [W-1:0] in_volt_beta_in = '0;
  logic out_strobe;
  logic signed [W-1:0] out_volt_alpha_out;
  logic signed [W-1:0] out_volt_beta_out;
  logic signed [W-1:0] out_correction_u;
  logic signed [W-1:0] out_correction_v;
  logic signed [W-1:0] out_correction_w;
  logic out_applied;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cfg_t regs;
  comp_word_t comp_due[$];
  int fail_count = 0;
  int idle_cycles = 0;

  deadtime_compensation_alpha_beta #(.VALUE_WIDTH(W)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_bus_voltage    (in_bus_voltage),
    .in_current_u      (in_current_u),
    .in_current_v      (in_current_v),
    .in_current_w      (in_current_w),
    .in_volt_alpha_in  (in_volt_alpha_in),
    .in_volt_beta_in   (in_volt_beta_in),
    .out_strobe        (out_strobe),
    .out_volt_alpha_out(out_volt_alpha_out),
    .out_volt_beta_out (out_volt_beta_out),
    .out_correction_u  (out_correction_u),
    .out_correction_v  (out_correction_v),
    .out_correction_w  (out_correction_w),
    .out_applied       (out_applied),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round to nearest, halves away from zero; den is positive
  function automatic longint round_div(longint num, longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end else begin
      return -((-num + den / 2) / den);
    end
  endfunction

  function automatic longint clamp_word(longint x);
    longint hi;
    longint lo;
    hi = (longint'(1) << (W - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Smoothed current sign in Q15: hard sign for a zero band, else linear
  function automatic longint current_sign(longint i, longint band);
    if (band == 0) begin
      if (i > 0) return SIGN_FULL;
      if (i < 0) return -SIGN_FULL;
      return 0;
    end
    if (i >= band) return SIGN_FULL;
    if (i <= -band) return -SIGN_FULL;
    return (i * SIGN_FULL) / band;
  endfunction

  // Predict the compensated command for one sample under the current registers
  function automatic comp_word_t compensate(sample_word_t s);
    longint k;
    longint vbus;
    longint m;
    longint va;
    longint vb;
    longint cur[3];
    longint d[3];
    longint c[3];
    comp_word_t r;
    vbus = longint'(s.bus);
    va = longint'($signed(s.va));
    vb = longint'($signed(s.vb));
    cur[0] = longint'($signed(s.iu));
    cur[1] = longint'($signed(s.iv));
    cur[2] = longint'($signed(s.iw));
    k = (regs.gain_base < regs.gain_max) ? longint'(regs.gain_base)
                                          : longint'(regs.gain_max);
    if (vbus < longint'(regs.min_bus) || k == 0) begin
      r.va_out = s.va;
      r.vb_out = s.vb;
      r.cor_u = '0;
      r.cor_v = '0;
      r.cor_w = '0;
      r.applied = 1'b0;
      return r;
    end
    m = (k * vbus + 32768) / 65536;
    for (int j = 0; j < 3; j++) begin
      d[j] = round_div(m * current_sign(cur[j], longint'(regs.cur_th)), 32768);
      if (regs.negate) d[j] = -d[j];
    end
    // Remove the common mode of the three phase corrections
    c[0] = round_div(2 * d[0] - d[1] - d[2], 3);
    c[1] = round_div(2 * d[1] - d[0] - d[2], 3);
    c[2] = round_div(2 * d[2] - d[0] - d[1], 3);
    r.va_out = W'(clamp_word(va + c[0]));
    r.vb_out = W'(clamp_word(vb + round_div((d[1] - d[2]) * RECIP_SQRT3, 65536)));
    r.cor_u = W'(clamp_word(c[0]));
    r.cor_v = W'(clamp_word(c[1]));
    r.cor_w = W'(clamp_word(c[2]));
    r.applied = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic wr_en, cfg_idx_t idx, logic [15:0] data,
                                       sample_word_t smp, logic typed,
                                       logic [W-1:0] wa, logic [W-1:0] wb);
    dir_row_t r;
    r.wr_en = wr_en;
    r.wr_idx = idx;
    r.wr_data = data;
    r.smp = smp;
    r.typed = typed;
    r.want_a = wa;
    r.want_b = wb;
    return r;
  endfunction

  // Phase current: mostly around the sign band, plus zero, extremes and noise
  function automatic logic [W-1:0] pick_current();
    int unsigned pick;
    longint band;
    longint v;
    pick = $urandom_range(0, 9);
    band = longint'(regs.cur_th);
    if (pick < 6) begin
      if (band == 0) v = longint'($urandom_range(0, 6)) - 3;
      else v = longint'($urandom_range(0, int'(2 * band + 4))) - band - 2;
      return W'(clamp_word(v));
    end
    if (pick == 6) return '0;
    if (pick == 7) return $urandom_range(0, 1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
    return W'($urandom);
  endfunction

  function automatic logic [W-1:0] pick_voltage();
    if ($urandom_range(0, 9) < 2) begin
      return $urandom_range(0, 1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
    end
    return W'($urandom);
  endfunction

  function automatic sample_word_t next_sample();
    sample_word_t s;
    int unsigned pick;
    longint near_min;
    pick = $urandom_range(0, 9);
    near_min = longint'(regs.min_bus) + longint'($urandom_range(0, 4)) - 2;
    if (near_min < 0) near_min = 0;
    if (near_min > 65535) near_min = 65535;
    case (pick)
      0: s.bus = '0;
      1: s.bus = '1;
      2, 3: s.bus = W'(near_min);
      default: s.bus = W'($urandom);
    endcase
    s.iu = pick_current();
    s.iv = pick_current();
    s.iw = pick_current();
    s.va = pick_voltage();
    s.vb = pick_voltage();
    return s;
  endfunction

  function automatic void check_field(string name, logic [W-1:0] want, logic [W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endfunction

  // Hand one word to the block and queue its expected result on acceptance
  task automatic send(sample_word_t s, comp_word_t want);
    in_bus_voltage <= s.bus;
    in_current_u <= s.iu;
    in_current_v <= s.iv;
    in_current_w <= s.iw;
    in_volt_alpha_in <= s.va;
    in_volt_beta_in <= s.vb;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    comp_due.push_back(want);
  endtask

  // Drop start and hold until every queued result has come back
  task automatic quiesce();
    start <= 1'b0;
    while (comp_due.size() != 0) @(posedge clk);
  endtask

  // Write one register; leaves cfg_valid high for the caller to drop
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_IDX_MIN_BUS:   regs.min_bus = data;
      CFG_IDX_GAIN_BASE: regs.gain_base = data;
      CFG_IDX_GAIN_MAX:  regs.gain_max = data;
      CFG_IDX_CUR_TH:    regs.cur_th = data[TH_W-1:0];
      CFG_IDX_NEGATE:    regs.negate = data[0];
      default: ;
    endcase
  endtask

  // Compare each result word against the oldest expectation
  always @(posedge clk) begin : result_check
    comp_word_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (comp_due.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = comp_due.pop_front();
        check_field("volt_alpha_out", want.va_out, out_volt_alpha_out);
        check_field("volt_beta_out", want.vb_out, out_volt_beta_out);
        check_field("correction_u", want.cor_u, out_correction_u);
        check_field("correction_v", want.cor_v, out_correction_v);
        check_field("correction_w", want.cor_w, out_correction_w);
        check_field("applied", W'(want.applied), W'(out_applied));
      end
    end
  end

  // Count cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $error("no progress for %0d cycles", STALL_LIMIT);
    $display("deadtime_compensation_alpha_beta_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_rows[$];
    dir_row_t row;
    comp_word_t want;
    sample_word_t smp;
    cfg_idx_t reg_order[5];
    logic [15:0] reg_val[5];
    int unsigned pick;
    int gap;
    int pause_at;
    bit calm;

    regs = '{min_bus: '0, gain_base: '0, gain_max: GAIN_MAX_RST, cur_th: '0, negate: 1'b0};
    reg_order = '{CFG_IDX_MIN_BUS, CFG_IDX_GAIN_BASE, CFG_IDX_GAIN_MAX,
                  CFG_IDX_CUR_TH, CFG_IDX_NEGATE};

    // Reset values: zero gain, so the first rows pass the command through
    dir_rows.push_back(dir_row(ROW_PLAIN, CFG_IDX_MIN_BUS, 16'h0000,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, ROW_TYPED, 16'h0000, 16'h0000));
    dir_rows.push_back(dir_row(ROW_PLAIN, CFG_IDX_MIN_BUS, 16'h0000,
      '{16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000}, ROW_TYPED, 16'h7FFF, 16'h8000));
    dir_rows.push_back(dir_row(ROW_PLAIN, CFG_IDX_MIN_BUS, 16'h0000,
      '{16'h8000, 16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 16'h7FFF}, ROW_TYPED, 16'h8000, 16'h7FFF));
    // Full gain, hard sign: saturating corrections and equal currents
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_GAIN_BASE, 16'hFFFF,
      '{16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}, ROW_PRED, '0, '0));
    dir_rows.push_back(dir_row(ROW_PLAIN, CFG_IDX_MIN_BUS, 16'h0000,
      '{16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, ROW_PRED, '0, '0));
    dir_rows.push_back(dir_row(ROW_PLAIN, CFG_IDX_MIN_BUS, 16'h0000,
      '{16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}, ROW_PRED, '0, '0));
    // Gain clamped by gain_max
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_GAIN_MAX, 16'h4000,
      '{16'h1234, 16'hFFFB, 16'h0003, 16'h0000, 16'h0100, 16'hFF00}, ROW_PRED, '0, '0));
    // Linear band of 200 (upper data bit masked off), edges and truncation
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_CUR_TH, 16'h80C8,
      '{16'hC000, 16'h0001, 16'hFFFF, 16'h00C7, 16'h0000, 16'h0000}, ROW_PRED, '0, '0));
    dir_rows.push_back(dir_row(ROW_PLAIN, CFG_IDX_MIN_BUS, 16'h0000,
      '{16'hC000, 16'h00C8, 16'hFF38, 16'hFF39, 16'h1000, 16'hF000}, ROW_PRED, '0, '0));
    dir_rows.push_back(dir_row(ROW_PLAIN, CFG_IDX_MIN_BUS, 16'h0000,
      '{16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h8000}, ROW_PRED, '0, '0));
    // Negated correction, only bit 0 of the data counts
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_NEGATE, 16'hFFFF,
      '{16'hC000, 16'h0096, 16'hFFF9, 16'h8000, 16'h8000, 16'h7FFF}, ROW_PRED, '0, '0));
    // Bus just under and at the minimum
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_MIN_BUS, 16'h1000,
      '{16'h0FFF, 16'h0064, 16'hFF9C, 16'h0000, 16'h1234, 16'hEDCC}, ROW_TYPED, 16'h1234, 16'hEDCC));
    dir_rows.push_back(dir_row(ROW_PLAIN, CFG_IDX_MIN_BUS, 16'h0000,
      '{16'h1000, 16'h0064, 16'hFF9C, 16'h0000, 16'h1234, 16'hEDCC}, ROW_PRED, '0, '0));
    // Writes past the register list change nothing
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_SPARE, 16'hFFFF,
      '{16'h8000, 16'h0064, 16'hFF9C, 16'h0032, 16'h0000, 16'h0000}, ROW_PRED, '0, '0));
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_TOP, 16'h0000,
      '{16'h8000, 16'h0032, 16'hFFCE, 16'h0000, 16'h0000, 16'h0000}, ROW_PRED, '0, '0));
    // Minimal gain: half-unit rounding of the correction amplitude
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_GAIN_BASE, 16'h0001,
      '{16'h8000, 16'h0064, 16'hFF9C, 16'h0032, 16'h0000, 16'h0000}, ROW_PRED, '0, '0));
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_GAIN_MAX, 16'hFFFF,
      '{16'hFFFF, 16'h0064, 16'hFF9C, 16'h0032, 16'h0000, 16'h0000}, ROW_PRED, '0, '0));
    // Zero gain bypasses, then zero bus with gain still applies
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_GAIN_BASE, 16'h0000,
      '{16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 16'h0ABC, 16'hF543}, ROW_TYPED, 16'h0ABC, 16'hF543));
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_MIN_BUS, 16'h0000,
      '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 16'h0000}, ROW_TYPED, 16'h0000, 16'h0000));
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_GAIN_BASE, 16'h8000,
      '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 16'h0000}, ROW_PRED, '0, '0));
    // Widest band, then back to hard sign with zero currents
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_CUR_TH, 16'h7FFF,
      '{16'hFFFF, 16'h3FFF, 16'hC001, 16'h7FFE, 16'h0000, 16'h0000}, ROW_PRED, '0, '0));
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_CUR_TH, 16'h0000,
      '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000}, ROW_PRED, '0, '0));
    dir_rows.push_back(dir_row(ROW_WRITE, CFG_IDX_NEGATE, 16'h0000,
      '{16'hA5A5, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000}, ROW_PRED, '0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table back to back
    foreach (dir_rows[n]) begin
      row = dir_rows[n];
      if (row.wr_en) begin
        quiesce();
        write_reg(row.wr_idx, row.wr_data);
        cfg_valid <= 1'b0;
      end
      if (row.typed) begin
        want = '{row.want_a, row.want_b, '0, '0, '0, 1'b0};
      end else begin
        want = compensate(row.smp);
      end
      send(row.smp, want);
    end

    // Random phases: new register set, then a burst of random samples
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiesce();
      case (ph)
        0: reg_val = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        1: reg_val = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
        default: begin
          pick = $urandom_range(0, 9);
          reg_val[0] = (pick < 5) ? 16'h0000 : (pick < 7) ? 16'($urandom_range(0, 16'h0FFF)) :
                       (pick == 7) ? 16'hFFFF : 16'($urandom);
          pick = $urandom_range(0, 9);
          reg_val[1] = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                       (pick == 2) ? 16'($urandom_range(1, 255)) : 16'($urandom);
          pick = $urandom_range(0, 9);
          reg_val[2] = (pick == 0) ? 16'h0000 : (pick < 3) ? 16'hFFFF : 16'($urandom);
          pick = $urandom_range(0, 9);
          reg_val[3] = (pick < 2) ? {1'($urandom), 15'h0000} : (pick == 2) ? 16'h7FFF :
                       (pick == 3) ? 16'h0001 : (pick < 7) ? 16'($urandom_range(1, 2000)) :
                       16'($urandom);
          reg_val[4] = 16'($urandom);
        end
      endcase
      foreach (reg_order[r]) begin
        gap = $urandom_range(0, 3);
        if (gap > 0 && r > 0) begin
          cfg_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        write_reg(reg_order[r], reg_val[r]);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE : CFG_IDX_TOP, 16'($urandom));
      end
      cfg_valid <= 1'b0;

      calm = (ph == 0) || ($urandom_range(0, 3) == 0);
      pause_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
      for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
        // Mostly back to back, some short gaps, a few long ones
        gap = 0;
        if (!calm) begin
          pick = $urandom_range(0, 9);
          if (pick > 8) gap = $urandom_range(10, 60);
          else if (pick > 5) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        if (it == pause_at) quiesce();
        smp = next_sample();
        send(smp, compensate(smp));
      end
    end

    // Drain, then give the pipeline time to show any stray word
    quiesce();
    repeat (OUT_LAT + 8) @(posedge clk);
    if (comp_due.size() != 0) begin
      $error("%0d result words never arrived", comp_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("deadtime_compensation_alpha_beta_tb: PASS");
    end else begin
      $display("deadtime_compensation_alpha_beta_tb: FAIL");
    end
    $finish;
  end

endmodule
